// File: rtl/tsrr_pkg.sv
`timescale 1ns / 1ps

package tsrr_pkg;

  localparam int NumSlotsDefault = 8;

  localparam int OpW       = 2;
  localparam int HandleW   = 32;
  localparam int ArgW      = 32;
  localparam int TaskIdW   = 3;
  localparam int StatusW   = 3;
  localparam int SlotOutW  = 3;

  localparam int InDataW   = 72;
  localparam int OutDataW  = 80;

  typedef enum logic [OpW-1:0] {
    OP_CREATE   = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_YIELD    = 2'd2,
    OP_RESTART  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NONE_RUN = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_NO_CUR   = 3'd4
  } status_e;

endpackage

// File: rtl/task_slot_round_robin_scheduler.sv
`timescale 1ns / 1ps
// An accepted request word lands in the request register; once the result register
// can take a word, the task table and the result register update together.
// One request word per cycle while the result side does not stall; the slot search is
// a rotating priority encoder over the runnable flags, and the handle memory is read in that same edge.
// Reset clears every runnable flag, the current task and both pipeline valids;
// the handle and argument memory is not cleared and is only returned for runnable slots.
module task_slot_round_robin_scheduler
  import tsrr_pkg::*;
#(
  parameter int NUM_SLOTS = NumSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_handle [31:0], arg_word [63:32], task_id [66:64], finished [67], zero [71:68]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status [2:0], slot [5:3], entry_out [37:6], arg_out [69:38],
  // current_valid [70], current_slot [73:71], zero [79:74]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam int SelW = (IdxW > SlotOutW) ? IdxW : SlotOutW;
  localparam int MemW = HandleW + ArgW;

  function automatic logic [IdxW-1:0] lowest_set(input logic [NUM_SLOTS-1:0] vec);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  // Request register.
  logic                 s1_valid_q;
  op_e                  op_q;
  logic [HandleW-1:0]   entry_q;
  logic [ArgW-1:0]      arg_q;
  logic [TaskIdW-1:0]   tid_q;
  logic                 fin_q;

  // Task table state.
  logic [NUM_SLOTS-1:0] run_q, run_d;
  logic [NUM_SLOTS-1:0] has_q, has_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]      cur_q, cur_d;
  logic [MemW-1:0]      slot_mem [NUM_SLOTS];

  // Result register.
  logic                 m_valid_q;
  status_e              res_status_q, res_status_d;
  logic [SlotOutW-1:0]  res_slot_q, res_slot_d;
  logic                 res_rd_q, res_rd_d;
  logic [MemW-1:0]      res_data_q;
  logic                 res_cur_valid_q;
  logic [SlotOutW-1:0]  res_cur_slot_q, res_cur_slot_d;

  logic                 advance;
  logic                 wr_en;
  logic [IdxW-1:0]      create_idx;
  logic [IdxW-1:0]      disp_idx;
  logic [IdxW:0]        base;
  logic [NUM_SLOTS-1:0] hi_mask;
  logic [IdxW-1:0]      slot_idx;
  logic [SelW-1:0]      slot_ext;
  logic [SelW-1:0]      cur_ext;
  logic [SelW-1:0]      tid_ext;
  logic [IdxW-1:0]      tid_idx;
  logic                 tid_ok;

  assign advance       = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;

  always_comb begin
    create_idx = lowest_set(~run_q);
    base = cur_valid_q ? ({1'b0, cur_q} + (IdxW + 1)'(1)) : '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hi_mask[i] = run_q[i] && ((IdxW + 1)'(i) >= base);
    end
    disp_idx = (|hi_mask) ? lowest_set(hi_mask) : lowest_set(run_q);
    tid_ext  = SelW'(tid_q);
    tid_idx  = tid_ext[IdxW-1:0];
    tid_ok   = (32'(tid_q) < NUM_SLOTS) && has_q[tid_idx];
  end

  always_comb begin
    run_d        = run_q;
    has_d        = has_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    res_status_d = ST_OK;
    res_rd_d     = 1'b0;
    slot_idx     = '0;
    wr_en        = 1'b0;
    unique case (op_q)
      OP_CREATE: begin
        if (&run_q) begin
          res_status_d = ST_FULL;
        end else begin
          wr_en              = 1'b1;
          slot_idx           = create_idx;
          run_d[create_idx]  = 1'b1;
          has_d[create_idx]  = |entry_q;
        end
      end
      OP_DISPATCH: begin
        if (!(|run_q)) begin
          res_status_d = ST_NONE_RUN;
          cur_valid_d  = 1'b0;
          cur_d        = '0;
        end else begin
          cur_valid_d = 1'b1;
          cur_d       = disp_idx;
          slot_idx    = disp_idx;
          res_rd_d    = 1'b1;
        end
      end
      OP_YIELD: begin
        if (!cur_valid_q) begin
          res_status_d = ST_NO_CUR;
        end else if (fin_q) begin
          run_d[cur_q] = 1'b0;
          has_d[cur_q] = 1'b0;
        end
      end
      OP_RESTART: begin
        if (!tid_ok) begin
          res_status_d = ST_NO_ENTRY;
        end else begin
          run_d[tid_idx] = 1'b1;
        end
      end
      default: begin
        res_status_d = ST_OK;
      end
    endcase
    slot_ext       = SelW'(slot_idx);
    res_slot_d     = slot_ext[SlotOutW-1:0];
    cur_ext        = SelW'(cur_d);
    res_cur_slot_d = cur_ext[SlotOutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      run_q       <= '0;
      has_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        m_valid_q   <= 1'b1;
        run_q       <= run_d;
        has_q       <= has_d;
        cur_valid_q <= cur_valid_d;
        cur_q       <= cur_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= op_e'(s_axis_tuser);
      entry_q <= s_axis_tdata[31:0];
      arg_q   <= s_axis_tdata[63:32];
      tid_q   <= s_axis_tdata[66:64];
      fin_q   <= s_axis_tdata[67];
    end
    if (advance) begin
      res_status_q    <= res_status_d;
      res_slot_q      <= res_slot_d;
      res_rd_q        <= res_rd_d;
      res_cur_valid_q <= cur_valid_d;
      res_cur_slot_q  <= res_cur_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && wr_en) begin
      slot_mem[create_idx] <= {arg_q, entry_q};
    end
    if (advance) begin
      res_data_q <= slot_mem[disp_idx];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0,
                          res_cur_slot_q,
                          res_cur_valid_q,
                          res_rd_q ? res_data_q[MemW-1:HandleW] : {ArgW{1'b0}},
                          res_rd_q ? res_data_q[HandleW-1:0] : {HandleW{1'b0}},
                          res_slot_q,
                          res_status_q};

  // A slot with a nonzero entry is always runnable.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (has_q & ~run_q) == '0)
    else $error("slot holds an entry but is not runnable");

  // Without a current task the round-robin position rests at slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !cur_valid_q |-> cur_q == '0)
    else $error("current slot nonzero with no current task");

  // An empty result register never blocks the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !m_valid_q |-> s_axis_tready)
    else $error("request side stalled with empty result register");

  // A failed dispatch always leaves no current task in its result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_status_q == ST_NONE_RUN) |-> !res_cur_valid_q)
    else $error("nothing runnable but a task reported current");

  // A dispatch that returns handle data must report success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_rd_q) |-> (res_status_q == ST_OK && res_cur_valid_q))
    else $error("dispatch data returned without a current task");

endmodule
